/* sv/sfr_pkg.sv */
`default_nettype none

package sfr_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CntW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_BYTES      = 8'd0,
    REG_PATTERN_LENGTH     = 8'd1,
    REG_REPLACEMENT_BYTES  = 8'd2,
    REG_REPLACEMENT_LENGTH = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       end_of_output;
  } out_res_t;

  // One emission job: bytes 0..count-1 of data, then the end marker if eot is set.
  typedef struct packed {
    logic [63:0]     data;
    logic [CntW-1:0] count;
    logic            eot;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/sfr_front.sv */
`default_nettype none

module sfr_front import sfr_pkg::*; #(
  parameter int unsigned MAX_PATTERN     = 8,
  parameter int unsigned MAX_REPLACEMENT = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic               accept_i,
  input  wire in_req_t            in_req_i,
  output logic                    q_push_o,
  output cmd_t                    cmd_o
);

  localparam int unsigned PatCap = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
  localparam int unsigned RplCap = (MAX_REPLACEMENT < 8) ? MAX_REPLACEMENT : 8;

  logic [63:0]     pattern_q;
  logic [CntW-1:0] plen_q;
  logic [63:0]     repl_q;
  logic [CntW-1:0] rlen_q;
  logic [7:0]      held_q [PatCap];
  logic [7:0]      held_d [PatCap];
  logic [CntW-1:0] held_cnt_q, held_cnt_d;

  logic [CntW-1:0] plen, rlen, n, n1, sh;
  logic [7:0]      w [PatCap];
  logic [63:0]     wpack;
  logic [PatCap:0] pre;
  logic            match;

  always_comb begin
    plen = plen_q;
    if (plen_q == '0) begin
      plen = CntW'(1);
    end else if (plen_q > CntW'(PatCap)) begin
      plen = CntW'(PatCap);
    end
    rlen = (rlen_q > CntW'(RplCap)) ? CntW'(RplCap) : rlen_q;
    n  = (held_cnt_q >= plen) ? '0 : held_cnt_q;
    n1 = n + CntW'(1);

    wpack = '0;
    for (int k = 0; k < PatCap; k++) begin
      w[k] = (CntW'(k) < n) ? held_q[k] : in_req_i.text_byte;
      wpack[8*k +: 8] = w[k];
    end

    // pre[s]: the window from s to the newest byte is a prefix of the pattern.
    for (int s = 0; s <= PatCap; s++) begin
      pre[s] = 1'b1;
      for (int j = 0; j < PatCap; j++) begin
        if (s + j < PatCap) begin
          if ((CntW'(s + j) < n1) && (w[s + j] != pattern_q[8*j +: 8])) begin
            pre[s] = 1'b0;
          end
        end
      end
    end
    match = (n1 == plen) && pre[0];

    sh = n1;
    for (int s = PatCap; s >= 0; s--) begin
      if (pre[s] && (CntW'(s) <= n1)) begin
        sh = CntW'(s);
      end
    end

    for (int k = 0; k < PatCap; k++) begin
      held_d[k] = held_q[k];
    end
    held_cnt_d = held_cnt_q;
    cmd_o = '{data: wpack, count: sh, eot: in_req_i.end_of_text};

    if (accept_i) begin
      for (int k = 0; k < PatCap; k++) begin
        held_d[k] = w[k];
        for (int s = 0; s < PatCap; s++) begin
          if ((sh == CntW'(s)) && (k + s < PatCap)) begin
            held_d[k] = w[k + s];
          end
        end
      end
      if (match) begin
        cmd_o.data  = repl_q;
        cmd_o.count = rlen;
      end else if (in_req_i.end_of_text) begin
        cmd_o.count = n1;
      end
      if (match || in_req_i.end_of_text) begin
        held_cnt_d = '0;
      end else begin
        held_cnt_d = n1 - sh;
      end
    end

    if (cfg_we_i && ((cfg_index_i == REG_PATTERN_BYTES) ||
                     (cfg_index_i == REG_PATTERN_LENGTH))) begin
      held_cnt_d = '0;
    end
  end

  assign q_push_o = accept_i && ((cmd_o.count != '0) || cmd_o.eot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= '0;
      plen_q     <= CntW'(1);
      repl_q     <= '0;
      rlen_q     <= '0;
      held_cnt_q <= '0;
    end else begin
      held_cnt_q <= held_cnt_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PATTERN_BYTES:      pattern_q <= cfg_data_i;
          REG_PATTERN_LENGTH:     plen_q    <= cfg_data_i[CntW-1:0];
          REG_REPLACEMENT_BYTES:  repl_q    <= cfg_data_i;
          REG_REPLACEMENT_LENGTH: rlen_q    <= cfg_data_i[CntW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < PatCap; k++) begin
      held_q[k] <= held_d[k];
    end
  end

endmodule

`default_nettype wire

/* sv/sfr_queue.sv */
`default_nettype none

module sfr_queue import sfr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      head_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

/* sv/sfr_back.sv */
`default_nettype none

module sfr_back import sfr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_empty_i,
  input  wire cmd_t head_i,
  output logic      q_pop_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output out_res_t  res_o
);

  logic [2:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  out_res_t   res_q, res_d;
  logic       load, last;

  always_comb begin
    load  = !q_empty_i && (!vld_q || pop_i);
    last  = (head_i.count == '0) || (({1'b0, idx_q} + CntW'(1)) == head_i.count);
    idx_d = idx_q;
    vld_d = vld_q;
    res_d = res_q;
    if (pop_i) begin
      vld_d = 1'b0;
    end
    if (load) begin
      vld_d              = 1'b1;
      res_d.byte_present = (head_i.count != '0);
      res_d.out_byte     = (head_i.count != '0) ? head_i.data[{idx_q, 3'b000} +: 8] : 8'd0;
      res_d.end_of_output = head_i.eot && last;
      idx_d = last ? 3'd0 : idx_q + 3'd1;
    end
  end

  assign q_pop_o = load && last;
  assign empty_o = !vld_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

`default_nettype wire

/* sv/stream_find_replace.sv */
// Channel     Direction  Handshake                 Payload
// input       in         push / full               in_req_i (text_byte, end_of_text)
// result      out        empty / pop               res_o (out_byte, byte_present, end_of_output)
// config      in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// The front classifies one byte per cycle while the two-entry command queue has room.
// The back delivers one result per cycle while results are popped, so a byte that releases k
// results holds the result side until all k are delivered; a bare end marker is one result.
// Reset is asynchronous and leaves no bytes held; configuration is always ready.
// A stalled result side fills the queue and then raises full.
`default_nettype none

module stream_find_replace import sfr_pkg::*; #(
  parameter int unsigned MAX_PATTERN     = 8,
  parameter int unsigned MAX_REPLACEMENT = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic               push,
  output logic                    full,
  input  wire in_req_t            in_req_i,
  output logic                    empty,
  input  wire logic               pop,
  output out_res_t                res_o
);

  logic q_push, q_pop, q_full, q_empty;
  cmd_t cmd, head;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;

  sfr_front #(
    .MAX_PATTERN    (MAX_PATTERN),
    .MAX_REPLACEMENT(MAX_REPLACEMENT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (push && !q_full),
    .in_req_i   (in_req_i),
    .q_push_o   (q_push),
    .cmd_o      (cmd)
  );

  sfr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .head_o (head)
  );

  sfr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .head_i   (head),
    .q_pop_o  (q_pop),
    .empty_o  (empty),
    .pop_i    (pop),
    .res_o    (res_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full)) else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty)) else $error("command popped from an empty queue");

  a_bare_marker_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_o.byte_present) |-> res_o.end_of_output)
    else $error("result without a byte is not the end marker");

endmodule

`default_nettype wire

/* dv/tb_stream_find_replace.sv */
module tb_stream_find_replace;
  import sfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned FINAL_SETTLE = 20;
  localparam int unsigned MAX_MISMATCH_PRINTS = 10;
  localparam int unsigned PAT_CAP = 8;
  localparam int unsigned RPL_CAP = 8;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_HI = 8'hff;

  class replace_scoreboard;
    logic [63:0] pat_word;
    logic [3:0]  pat_len_raw;
    logic [63:0] rep_word;
    logic [3:0]  rep_len_raw;
    logic [7:0]  held[PAT_CAP];
    int unsigned held_n;
    out_res_t    expected_out[$];
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned results_seen;
    int unsigned reg_writes;

    function new();
      pat_word = '0;
      pat_len_raw = 4'd1;
      rep_word = '0;
      rep_len_raw = 4'd0;
      held_n = 0;
      errors = 0;
      bytes_seen = 0;
      results_seen = 0;
      reg_writes = 0;
    endfunction

    function int unsigned eff_plen();
      int unsigned p;
      p = pat_len_raw;
      if (p < 1) p = 1;
      if (p > PAT_CAP) p = PAT_CAP;
      return p;
    endfunction

    function int unsigned eff_rlen();
      int unsigned r;
      r = rep_len_raw;
      if (r > RPL_CAP) r = RPL_CAP;
      return r;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
      reg_writes++;
      case (idx)
        REG_PATTERN_BYTES: begin
          pat_word = data;
          held_n = 0;
        end
        REG_PATTERN_LENGTH: begin
          pat_len_raw = data[3:0];
          held_n = 0;
        end
        REG_REPLACEMENT_BYTES: rep_word = data;
        REG_REPLACEMENT_LENGTH: rep_len_raw = data[3:0];
        default: ;
      endcase
    endfunction

    function bit held_is_prefix(int unsigned n);
      for (int unsigned k = 0; k < n; k++) begin
        if (held[k] != pat_word[8*k +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function out_res_t make_res(logic [7:0] b, logic present);
      out_res_t o;
      o.out_byte = b;
      o.byte_present = present;
      o.end_of_output = 1'b0;
      return o;
    endfunction

    function void note_text_byte(in_req_t r);
      out_res_t burst[$];
      int unsigned plen;
      int unsigned rlen;
      int unsigned n;
      plen = eff_plen();
      rlen = eff_rlen();
      n = held_n;
      bytes_seen++;
      if (n >= plen) n = 0;
      held[n] = r.text_byte;
      n++;
      if (n == plen && held_is_prefix(n)) begin
        for (int unsigned k = 0; k < rlen; k++) begin
          burst.push_back(make_res(rep_word[8*k +: 8], 1'b1));
        end
        n = 0;
      end else begin
        while (n > 0 && !held_is_prefix(n)) begin
          burst.push_back(make_res(held[0], 1'b1));
          for (int unsigned k = 0; k + 1 < n; k++) held[k] = held[k+1];
          n--;
        end
      end
      if (r.end_of_text) begin
        for (int unsigned k = 0; k < n; k++) burst.push_back(make_res(held[k], 1'b1));
        n = 0;
        if (burst.size() == 0) burst.push_back(make_res(8'h00, 1'b0));
        burst[burst.size()-1].end_of_output = 1'b1;
      end
      held_n = n;
      foreach (burst[i]) expected_out.push_back(burst[i]);
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      results_seen++;
      if (expected_out.size() == 0) begin
        errors++;
        if (errors <= MAX_MISMATCH_PRINTS)
          $display("Unexpected result %0d: byte %02h present %0b end %0b", results_seen,
                   got.out_byte, got.byte_present, got.end_of_output);
        return;
      end
      want = expected_out.pop_front();
      if (want.out_byte !== got.out_byte || want.byte_present !== got.byte_present ||
          want.end_of_output !== got.end_of_output) begin
        errors++;
        if (errors <= MAX_MISMATCH_PRINTS)
          $display("Mismatch on result %0d: expected byte %02h present %0b end %0b,",
                   results_seen, want.out_byte, want.byte_present, want.end_of_output,
                   " got byte %02h present %0b end %0b",
                   got.out_byte, got.byte_present, got.end_of_output);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0]        cfg_data_i = '0;
  logic               push = 1'b0;
  logic               full;
  in_req_t            in_req_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  out_res_t           res_o;

  replace_scoreboard sb = new();
  bit          idle_on = 1'b1;
  int unsigned pop_gap = 0;
  int unsigned cycle_count = 0;

  stream_find_replace i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_req_i   (in_req_i),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               sb.expected_out.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_result(res_o);
      if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        pop_gap = $urandom_range(0, 6);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic push_text_byte(logic [7:0] text_b, logic eot);
    in_req_t r;
    r.text_byte = text_b;
    r.end_of_text = eot;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (full);
    sb.note_text_byte(r);
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (sb.expected_out.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] with_low_nibble(logic [3:0] nib);
    logic [63:0] w;
    w = rand_word();
    w[3:0] = nib;
    return w;
  endfunction

  // Pattern bytes come from a two-letter alphabet so that self-overlapping
  // prefixes, partial matches and release of held bytes happen often.
  task automatic configure(logic [3:0] plen_raw, logic [3:0] rlen_raw,
                           output logic [7:0] alpha_a, output logic [7:0] alpha_b);
    logic [63:0] pat;
    alpha_a = 8'($urandom);
    alpha_b = 8'($urandom);
    pat = rand_word();
    for (int k = 0; k < 8; k++) pat[8*k +: 8] = ($urandom_range(0, 2) == 0) ? alpha_b : alpha_a;
    write_reg(REG_REPLACEMENT_BYTES, rand_word());
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, with_low_nibble(plen_raw));
    write_reg(REG_REPLACEMENT_LENGTH, with_low_nibble(rlen_raw));
    if ($urandom_range(0, 2) == 0)
      write_reg(($urandom_range(0, 1) == 0) ? REG_UNUSED_LO : REG_UNUSED_HI, rand_word());
  endtask

  task automatic run_texts(int unsigned n_items, logic [7:0] alpha_a, logic [7:0] alpha_b,
                           bit pause_midway);
    int unsigned sent;
    int unsigned len;
    int unsigned pos;
    int unsigned plen;
    int unsigned r;
    logic [7:0]  text_b;
    sent = 0;
    pos = 0;
    plen = sb.eff_plen();
    while (sent < n_items) begin
      len = $urandom_range(1, 24);
      if (len > n_items - sent) len = n_items - sent;
      for (int unsigned i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          if ($urandom_range(0, 7) == 0) pos = 0;
          text_b = sb.pat_word[8*pos +: 8];
          pos = (pos + 1) % plen;
        end else if (r < 85) begin
          text_b = ($urandom_range(0, 1) == 0) ? alpha_a : alpha_b;
          pos = 0;
        end else begin
          text_b = 8'($urandom);
          pos = 0;
        end
        push_text_byte(text_b, i == len - 1);
        sent++;
        if (pause_midway && sent == n_items / 2) wait_drain();
      end
    end
  endtask

  initial begin
    logic [63:0] pat;
    logic [7:0]  alpha_a;
    logic [7:0]  alpha_b;
    logic [3:0]  plen_seq[7];
    logic [3:0]  rlen_seq[7];
    plen_seq = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd12, 4'd5, 4'd2};
    rlen_seq = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'd8, 4'd2};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: single zero byte deleted, bare end marker on a lone deleted byte.
    push_text_byte(8'h00, 1'b0);
    push_text_byte(8'hff, 1'b1);
    push_text_byte(8'h00, 1'b1);
    wait_drain();

    // Pattern length zero acts as one; replacement length saturates at eight.
    pat = rand_word();
    pat[7:0] = 8'hff;
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, with_low_nibble(4'd0));
    write_reg(REG_REPLACEMENT_BYTES, rand_word());
    write_reg(REG_REPLACEMENT_LENGTH, with_low_nibble(4'd15));
    push_text_byte(8'hff, 1'b1);
    push_text_byte(8'h7e, 1'b0);
    push_text_byte(8'hff, 1'b1);
    wait_drain();

    // Pattern length saturates at eight; a deleted match at the end leaves a bare
    // end marker, and a prefix cut off by the end of text is flushed.
    pat = rand_word();
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, with_low_nibble(4'd15));
    write_reg(REG_REPLACEMENT_LENGTH, with_low_nibble(4'd0));
    for (int k = 0; k < 8; k++) push_text_byte(pat[8*k +: 8], k == 7);
    for (int k = 0; k < 6; k++) push_text_byte(pat[8*k +: 8], k == 5);
    wait_drain();

    // A pattern write in mid-text drops held bytes; other writes keep them.
    pat = rand_word();
    pat[15:0] = 16'h6261;
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, with_low_nibble(4'd2));
    write_reg(REG_REPLACEMENT_LENGTH, with_low_nibble(4'd3));
    push_text_byte(8'h61, 1'b0);
    wait_drain();
    write_reg(REG_PATTERN_LENGTH, with_low_nibble(4'd2));
    push_text_byte(8'h62, 1'b1);
    push_text_byte(8'h61, 1'b0);
    wait_drain();
    write_reg(REG_UNUSED_LO, rand_word());
    write_reg(REG_UNUSED_HI, rand_word());
    write_reg(REG_REPLACEMENT_BYTES, rand_word());
    write_reg(REG_REPLACEMENT_LENGTH, with_low_nibble(4'd2));
    push_text_byte(8'h62, 1'b1);
    wait_drain();

    foreach (plen_seq[p]) begin
      if (p == 6) idle_on = 1'b0;
      configure(plen_seq[p], rlen_seq[p], alpha_a, alpha_b);
      run_texts(28, alpha_a, alpha_b, p == 2);
      wait_drain();
    end

    repeat (FINAL_SETTLE) @(posedge clk_i);
    $display("Covered %0d text bytes and %0d results after %0d register writes,",
             sb.bytes_seen, sb.results_seen, sb.reg_writes);
    $display("pattern lengths 1 to 8, replacement lengths 0 to 8; %0d mismatches.", sb.errors);
    if (sb.errors == 0 && sb.expected_out.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
